// File: src/pfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, register indexes and the pixel expansion function of the
// palette format conversion table.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS_PER_PALETTE = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [4:0]  PALETTE_COUNT_RESET = 5'd1;
    localparam logic [8:0]  COLORS_RESET        = 9'd256;
    localparam logic [15:0] RGB565_COLOR_KEY    = 16'hF81F;
    localparam logic [7:0]  ALPHA_OPAQUE        = 8'hFF;

    typedef enum logic [1:0] {
        FMT_ARGB8888 = 2'd0,
        FMT_ARGB4444 = 2'd1,
        FMT_ARGB1555 = 2'd2,
        FMT_RGB565   = 2'd3
    } pfc_fmt_t;

    typedef struct packed {
        logic        is_lookup;
        logic        oor;
        logic [31:0] color;
    } pfc_cmd_t;

    typedef struct packed {
        logic [31:0] color;
        logic        oor;
    } pfc_result_t;

    function automatic logic [31:0] expand_pixel(pfc_fmt_t fmt, logic [31:0] raw);
        logic [15:0] h;
        logic [31:0] res;
        h = raw[15:0];
        case (fmt)
            FMT_ARGB8888:
            begin
                res = raw;
            end
            FMT_ARGB4444:
            begin
                res = {h[15:12], h[15:12], h[11:8], h[11:8],
                       h[7:4], h[7:4], h[3:0], h[3:0]};
            end
            FMT_ARGB1555:
            begin
                if (!h[15])
                    res = 32'd0;
                else
                    res = {ALPHA_OPAQUE, h[14:10], 3'b000, h[9:5], 3'b000,
                           h[4:0], 3'b000};
            end
            FMT_RGB565:
            begin
                if (h == RGB565_COLOR_KEY)
                    res = 32'd0;
                else
                    res = {ALPHA_OPAQUE, h[15:11], 3'b000, h[10:5], 2'b00,
                           h[4:0], 3'b000};
            end
            default:
            begin
                res = raw;
            end
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/palette_format_convert_table.sv
`default_nettype none
// The single store port is read with a registered read ahead of the result FIFO.
// Throughput: one item (load or lookup) per cycle while lookups have result credit.
// Loads produce no result; out-of-range loads are dropped at the front.
// Reset: queues empty, config at defaults (ARGB8888, 1 palette, 256 colors).
// The palette store is not cleared; entries are undefined until loaded.
// ----------------------------------------------------------------------------
// palette_format_convert_table
// Palette store with ARGB8888 expansion: front classifies items, a command
// queue decouples it from the store and result path.
// ----------------------------------------------------------------------------
module palette_format_convert_table #(
    parameter int MAX_PALETTES = 16,
    parameter int MAX_COLORS   = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [pfc_pkg::CFG_IDX_W-1:0]  wr_addr,
    input  wire logic [pfc_pkg::CFG_DATA_W-1:0] wr_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic                          opcode,
    input  wire logic [31:0]                   raw_pixel,
    input  wire logic [3:0]                    palette_number,
    input  wire logic [7:0]                    entry_number,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [31:0]                        color_argb,
    output logic                               out_of_range
);
    import pfc_pkg::*;

    localparam int STORE_DEPTH = MAX_PALETTES * MAX_COLORS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CMD_W       = $bits(pfc_cmd_t) + ADDR_W;
    localparam int CMD_DEPTH   = 2;

    logic              f_push;
    pfc_cmd_t          f_cmd;
    logic [ADDR_W-1:0] f_addr;
    logic              cq_empty;
    logic              cq_pop;
    logic [CMD_W-1:0]  cq_rdata;
    logic [$clog2(CMD_DEPTH+1)-1:0] cq_count;
    pfc_cmd_t          b_cmd;
    logic [ADDR_W-1:0] b_addr;

    pfc_front #(
        .MAX_PALETTES (MAX_PALETTES),
        .MAX_COLORS   (MAX_COLORS),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .push           (push),
        .opcode         (opcode),
        .raw_pixel      (raw_pixel),
        .palette_number (palette_number),
        .entry_number   (entry_number),
        .q_full         (full),
        .q_push         (f_push),
        .q_cmd          (f_cmd),
        .q_addr         (f_addr)
    );

    pfc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_cmd, f_addr}),
        .full  (full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty),
        .count (cq_count)
    );

    assign {b_cmd, b_addr} = cq_rdata;

    pfc_back #(
        .ADDR_W      (ADDR_W),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cq_empty),
        .cmd          (b_cmd),
        .cmd_addr     (b_addr),
        .cmd_pop      (cq_pop),
        .empty        (empty),
        .pop          (pop),
        .color_argb   (color_argb),
        .out_of_range (out_of_range)
    );

`ifndef SYNTHESIS
    a_cq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cq_count) <= CMD_DEPTH)
        else $error("command queue count out of bound");

    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !cq_empty)
        else $error("command queue full and empty at once");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> !cq_empty)
        else $error("command popped from empty queue");
`endif

endmodule
`default_nettype wire

// File: src/pfc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_queue
// Small register FIFO with push/full and pop/empty, simultaneous push and
// pop allowed. Push while full and pop while empty are ignored.
// ----------------------------------------------------------------------------
module pfc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             wdata,
    output logic                              full,
    input  wire logic                         pop,
    output logic [WIDTH-1:0]                  rdata,
    output logic                              empty,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    wr_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= wdata;
    end

endmodule
`default_nettype wire

// File: src/pfc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_front
// Configuration registers, range check, address forming and pixel expansion.
// Out-of-range loads are dropped here; everything else goes to the queue.
// ----------------------------------------------------------------------------
module pfc_front #(
    parameter int MAX_PALETTES = 16,
    parameter int MAX_COLORS   = 256,
    parameter int ADDR_W       = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [pfc_pkg::CFG_IDX_W-1:0]  wr_addr,
    input  wire logic [pfc_pkg::CFG_DATA_W-1:0] wr_data,
    input  wire logic                          push,
    input  wire logic                          opcode,
    input  wire logic [31:0]                   raw_pixel,
    input  wire logic [3:0]                    palette_number,
    input  wire logic [7:0]                    entry_number,
    input  wire logic                          q_full,
    output logic                               q_push,
    output pfc_pkg::pfc_cmd_t                  q_cmd,
    output logic [ADDR_W-1:0]                  q_addr
);
    import pfc_pkg::*;

    pfc_fmt_t    fmt_reg;
    logic [4:0]  pal_count_reg;
    logic [8:0]  colors_reg;
    logic        pal_oor;
    logic        ent_oor;
    logic        oor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_ARGB8888;
            pal_count_reg <= PALETTE_COUNT_RESET;
            colors_reg    <= COLORS_RESET;
        end
        else if (wr_en)
        begin
            case (wr_addr)
                REG_PIXEL_FORMAT:       fmt_reg       <= pfc_fmt_t'(wr_data[1:0]);
                REG_PALETTE_COUNT:      pal_count_reg <= wr_data[4:0];
                REG_COLORS_PER_PALETTE: colors_reg    <= wr_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pal_oor = ({1'b0, palette_number} >= pal_count_reg) ||
                  (32'(palette_number) >= MAX_PALETTES);
        ent_oor = ({1'b0, entry_number} >= colors_reg) ||
                  (32'(entry_number) >= MAX_COLORS);
        oor     = pal_oor || ent_oor;

        q_cmd.is_lookup = (opcode == OP_LOOKUP);
        q_cmd.oor       = oor;
        q_cmd.color     = expand_pixel(fmt_reg, raw_pixel);
        q_addr          = ADDR_W'(32'(palette_number) * MAX_COLORS + 32'(entry_number));
        q_push          = push && !q_full && ((opcode == OP_LOOKUP) || !oor);
    end

endmodule
`default_nettype wire

// File: src/pfc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfc_back
// Palette store and result path. Loads write the store; lookups read it with
// a registered read and land in a result FIFO guarded by a credit check.
// ----------------------------------------------------------------------------
module pfc_back #(
    parameter int ADDR_W      = 12,
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_empty,
    input  wire pfc_pkg::pfc_cmd_t  cmd,
    input  wire logic [ADDR_W-1:0]  cmd_addr,
    output logic                    cmd_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic [31:0]             color_argb,
    output logic                    out_of_range
);
    import pfc_pkg::*;

    localparam int RES_DEPTH = 4;
    localparam int RCW       = $clog2(RES_DEPTH+1);

    logic [31:0]  store_mem [STORE_DEPTH];
    logic [31:0]  rd_data_reg;
    logic         inflight_reg;
    logic         inflight_oor_reg;
    logic         credit;
    logic         mem_we;
    logic         mem_re;
    logic         res_full;
    logic [RCW-1:0] res_count;
    pfc_result_t  res_in;
    pfc_result_t  res_out;

    always_comb
    begin
        credit  = (32'(res_count) + 32'(inflight_reg)) < RES_DEPTH;
        mem_we  = !cmd_empty && !cmd.is_lookup;
        mem_re  = !cmd_empty && cmd.is_lookup && credit;
        cmd_pop = mem_we || mem_re;
        res_in.color = inflight_oor_reg ? 32'd0 : rd_data_reg;
        res_in.oor   = inflight_oor_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[cmd_addr] <= cmd.color;
        if (mem_re)
            rd_data_reg <= store_mem[cmd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg     <= 1'b0;
            inflight_oor_reg <= 1'b0;
        end
        else
        begin
            inflight_reg     <= mem_re;
            inflight_oor_reg <= mem_re && cmd.oor;
        end
    end

    pfc_queue #(
        .WIDTH ($bits(pfc_result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (inflight_reg),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty),
        .count (res_count)
    );

    assign color_argb   = res_out.color;
    assign out_of_range = res_out.oor;

`ifndef SYNTHESIS
    a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg |-> !res_full)
        else $error("result fifo overflow");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(res_count) + 32'(inflight_reg)) <= RES_DEPTH)
        else $error("result credit exceeded");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_re && cmd.oor) |=> (res_in.color == 32'd0))
        else $error("out-of-range lookup returned nonzero color");
`endif

endmodule
`default_nettype wire

// File: dv/tb_palette_format_convert_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_format_convert_table
// Self-checking bench for the palette store. Loads and lookups go in through
// the push side and lookup colors are popped out. A shadow palette store and
// its own format expansion predict every lookup result. Directed items cover
// the reset setup, each source format, the color key, a clear alpha bit,
// zero counts and counts above the maximum. Random phases follow, each with
// a new register setup. Random idle bursts are applied on both sides.
// ----------------------------------------------------------------------------
module tb_palette_format_convert_table;

    import pfc_pkg::*;

    localparam int MAX_PAL     = 16;
    localparam int MAX_COL     = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic        op;
        logic [31:0] raw;
        logic [3:0]  pal;
        logic [7:0]  ent;
    } pix_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_addr = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  opcode = OP_LOAD;
    logic [31:0]           raw_pixel = '0;
    logic [3:0]            palette_number = '0;
    logic [7:0]            entry_number = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [31:0]           color_argb;
    logic                  out_of_range;

    // register shadows
    pfc_fmt_t   fmt_cfg = FMT_ARGB8888;
    logic [4:0] pal_cnt_cfg = PALETTE_COUNT_RESET;
    logic [8:0] colors_cfg = COLORS_RESET;

    logic [31:0] argb_shadow [0:MAX_PAL*MAX_COL-1];
    bit          entry_loaded [0:MAX_PAL*MAX_COL-1];
    logic [11:0] loaded_addrs [$];

    pix_item_t   pending_items [$];
    pfc_result_t lookups_due [$];
    pix_item_t   cur_item;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int pop_stall = 0;
    int mismatches = 0;
    int cycle_cnt = 0;
    int ph;
    int v;

    palette_format_convert_table #(
        .MAX_PALETTES (MAX_PAL),
        .MAX_COLORS   (MAX_COL)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .raw_pixel      (raw_pixel),
        .palette_number (palette_number),
        .entry_number   (entry_number),
        .empty          (empty),
        .pop            (pop),
        .color_argb     (color_argb),
        .out_of_range   (out_of_range)
    );

    always #6 clk = ~clk;

    function automatic int eff_palettes();
        return (pal_cnt_cfg > MAX_PAL) ? MAX_PAL : int'(pal_cnt_cfg);
    endfunction

    function automatic int eff_colors();
        return (colors_cfg > MAX_COL) ? MAX_COL : int'(colors_cfg);
    endfunction

    function automatic bit in_range(logic [3:0] pal, logic [7:0] ent);
        return (int'(pal) < eff_palettes()) && (int'(ent) < eff_colors());
    endfunction

    function automatic logic [31:0] to_argb(pfc_fmt_t fmt, logic [31:0] raw);
        logic [31:0] w;
        logic [31:0] argb;
        int n;
        w = {16'd0, raw[15:0]};
        argb = 32'd0;
        case (fmt)
            FMT_ARGB8888:
            begin
                argb = raw;
            end
            FMT_ARGB4444:
            begin
                for (n = 0; n < 4; n++)
                    argb[n*8 +: 8] = {2{w[n*4 +: 4]}};
            end
            FMT_ARGB1555:
            begin
                if (w[15])
                    argb = 32'hFF00_0000 | ((w & 32'h7C00) << 9) |
                           ((w & 32'h03E0) << 6) | ((w & 32'h001F) << 3);
            end
            default:
            begin
                if (w[15:0] != RGB565_COLOR_KEY)
                    argb = 32'hFF00_0000 | ((w & 32'hF800) << 8) |
                           ((w & 32'h07E0) << 5) | ((w & 32'h001F) << 3);
            end
        endcase
        return argb;
    endfunction

    // apply one accepted item to the shadow store
    task automatic predict_item(pix_item_t it);
        pfc_result_t res;
        bit hit;
        hit = in_range(it.pal, it.ent);
        if (it.op == OP_LOAD)
        begin
            if (hit)
                argb_shadow[{it.pal, it.ent}] = to_argb(fmt_cfg, it.raw);
        end
        else
        begin
            res.color = hit ? argb_shadow[{it.pal, it.ent}] : 32'd0;
            res.oor = !hit;
            lookups_due.push_back(res);
        end
    endtask

    task automatic add_load(logic [3:0] pal, logic [7:0] ent, logic [31:0] raw);
        pix_item_t it;
        it.op = OP_LOAD;
        it.raw = raw;
        it.pal = pal;
        it.ent = ent;
        if (in_range(pal, ent) && !entry_loaded[{pal, ent}])
        begin
            entry_loaded[{pal, ent}] = 1'b1;
            loaded_addrs.push_back({pal, ent});
        end
        pending_items.push_back(it);
    endtask

    task automatic add_lookup(logic [3:0] pal, logic [7:0] ent);
        pix_item_t it;
        it.op = OP_LOOKUP;
        it.raw = $urandom;
        it.pal = pal;
        it.ent = ent;
        pending_items.push_back(it);
    endtask

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_addr <= idx;
        wr_data <= val;
        case (idx)
            REG_PIXEL_FORMAT:       fmt_cfg = pfc_fmt_t'(val[1:0]);
            REG_PALETTE_COUNT:      pal_cnt_cfg = val[4:0];
            REG_COLORS_PER_PALETTE: colors_cfg = val[8:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // everything sent and answered, plus a wait for trailing loads
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || push || lookups_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int np;
        int nc;
        int pick;
        int tries;
        logic [3:0]  pal;
        logic [7:0]  ent;
        logic [31:0] raw;
        logic [11:0] a;
        bit found;
        np = eff_palettes();
        nc = eff_colors();
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            raw = $urandom;
            if (fmt_cfg == FMT_RGB565 && $urandom_range(0, 15) == 0)
                raw[15:0] = RGB565_COLOR_KEY;
            pal = '0;
            ent = '0;
            found = 1'b0;
            if (pick >= 45 && pick < 85)
            begin
                for (tries = 0; tries < 16 && !found; tries++)
                begin
                    if (tries < 8 && np > 0 && nc > 0)
                    begin
                        pal = 4'($urandom_range(0, np - 1));
                        ent = 8'($urandom_range(0, nc - 1));
                    end
                    else if (loaded_addrs.size() != 0)
                    begin
                        a = loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)];
                        pal = a[11:8];
                        ent = a[7:0];
                    end
                    found = in_range(pal, ent) && entry_loaded[{pal, ent}];
                end
                if (found)
                    add_lookup(pal, ent);
            end
            if (!found)
            begin
                if (pick < 85 && np > 0 && nc > 0)
                    add_load(4'($urandom_range(0, np - 1)), 8'($urandom_range(0, nc - 1)),
                             raw);
                else if (pick >= 85 && pick < 93 && (np < MAX_PAL || nc < MAX_COL))
                begin
                    if (np < MAX_PAL && (nc >= MAX_COL || $urandom_range(0, 1) == 1))
                    begin
                        pal = 4'($urandom_range(np, MAX_PAL - 1));
                        ent = 8'($urandom);
                    end
                    else
                    begin
                        pal = 4'($urandom);
                        ent = 8'($urandom_range(nc, MAX_COL - 1));
                    end
                    add_lookup(pal, ent);
                end
                else
                    add_load(4'($urandom), 8'($urandom), raw);
            end
        end
    endtask

    // push side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_item(cur_item);
            if (!push || !full)
            begin
                if (send_gap != 0)
                begin
                    send_gap = send_gap - 1;
                    push <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 9);
                    push <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    cur_item = pending_items.pop_front();
                    push <= 1'b1;
                    opcode <= cur_item.op;
                    raw_pixel <= cur_item.raw;
                    palette_number <= cur_item.pal;
                    entry_number <= cur_item.ent;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // pop side and checking
    always @(posedge clk)
    begin
        pfc_result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("unexpected item: color_argb=%h out_of_range=%b",
                           color_argb, out_of_range);
                    mismatches++;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (color_argb !== want.color)
                    begin
                        $error("color_argb: expected %h, got %h", want.color, color_argb);
                        mismatches++;
                    end
                    if (out_of_range !== want.oor)
                    begin
                        $error("out_of_range: expected %b, got %b", want.oor, out_of_range);
                        mismatches++;
                    end
                end
            end
            if (pop_stall != 0)
            begin
                pop_stall = pop_stall - 1;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                pop_stall = $urandom_range(0, 9);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("palette_format_convert_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setup: ARGB8888, one palette, 256 colors
        add_load(4'd0, 8'd0, 32'hFFFF_FFFF);
        add_load(4'd0, 8'd255, 32'h0000_0000);
        add_lookup(4'd0, 8'd0);
        add_lookup(4'd0, 8'd255);
        add_lookup(4'd1, 8'd0);
        add_load(4'd2, 8'd7, 32'h5A5A_A5A5);
        add_lookup(4'd15, 8'd255);
        wait_quiet();

        program_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_ARGB4444));
        program_reg(REG_PALETTE_COUNT, 9'd16);
        program_reg(REG_COLORS_PER_PALETTE, 9'd256);
        @(negedge clk);
        add_load(4'd15, 8'd255, 32'h1234_ABCD);
        add_lookup(4'd15, 8'd255);
        wait_quiet();

        // alpha bit clear, minimum and maximum opaque values
        program_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_ARGB1555));
        @(negedge clk);
        add_load(4'd15, 8'd0, 32'hFFFF_7FFF);
        add_lookup(4'd15, 8'd0);
        add_load(4'd15, 8'd1, 32'h0000_8000);
        add_lookup(4'd15, 8'd1);
        add_load(4'd15, 8'd2, 32'h0000_FFFF);
        add_lookup(4'd15, 8'd2);
        wait_quiet();

        // color key with upper half set, and one code next to the key
        program_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB565));
        @(negedge clk);
        add_load(4'd14, 8'd0, {16'hABCD, RGB565_COLOR_KEY});
        add_load(4'd14, 8'd1, 32'h0000_F81E);
        add_lookup(4'd14, 8'd0);
        add_lookup(4'd14, 8'd1);
        wait_quiet();

        // zero counts: everything out of range, load dropped
        program_reg(REG_PALETTE_COUNT, 9'd0);
        program_reg(REG_COLORS_PER_PALETTE, 9'd0);
        @(negedge clk);
        add_lookup(4'd0, 8'd0);
        add_load(4'd0, 8'd0, 32'h0000_0000);
        wait_quiet();

        // counts above the maximum saturate
        program_reg(REG_PALETTE_COUNT, 9'd31);
        program_reg(REG_COLORS_PER_PALETTE, 9'd511);
        @(negedge clk);
        add_lookup(4'd15, 8'd255);
        add_lookup(4'd0, 8'd0);

        for (ph = 0; ph < 10; ph++)
        begin
            wait_quiet();
            idle_on = (ph != 3) && (ph < 8);
            program_reg(REG_PIXEL_FORMAT,
                        CFG_DATA_W'((ph < 4) ? ph : int'($urandom_range(0, 3))));
            case ($urandom_range(0, 2))
                0:       v = MAX_PAL;
                1:       v = $urandom_range(17, 31);
                default: v = $urandom_range(1, MAX_PAL);
            endcase
            program_reg(REG_PALETTE_COUNT, CFG_DATA_W'(v));
            case ($urandom_range(0, 3))
                0:       v = MAX_COL;
                1:       v = $urandom_range(257, 511);
                2:       v = $urandom_range(1, 8);
                default: v = $urandom_range(1, MAX_COL);
            endcase
            program_reg(REG_COLORS_PER_PALETTE, CFG_DATA_W'(v));
            @(negedge clk);
            random_phase(170);
        end
        wait_quiet();

        if (mismatches == 0)
            $display("palette_format_convert_table: match");
        else
            $display("palette_format_convert_table: mismatch");
        $finish;
    end

endmodule

// File: palette_format_convert_table.f
src/pfc_pkg.sv
src/pfc_queue.sv
src/pfc_front.sv
src/pfc_back.sv
src/palette_format_convert_table.sv
dv/tb_palette_format_convert_table.sv
